[design/overwriting_fifo_packetizer_top_macros.svh]
// Assertion macros for the packetizer checker.
`ifndef OVERWRITING_FIFO_PACKETIZER_TOP_MACROS_SVH
`define OVERWRITING_FIFO_PACKETIZER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define OFP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define OFP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(ante) |=> (cons)) else $error(msg);

`endif

[design/ofp_pkg.sv]
// Shared types and constants for the overwriting FIFO packetizer.
package ofp_pkg;

	localparam int BUFFER_BYTES_DEF      = 481;
	localparam int PACKET_BYTES_DEF      = 48;
	localparam int PACKETS_PER_ROUND_DEF = 10;

	localparam int OP_W    = 2;
	localparam int BYTE_W  = 8;
	localparam int SPACE_W = 9;
	localparam int ROUND_W = 4;

	typedef enum logic [OP_W-1:0] {
		OP_WRITE = 2'd0,
		OP_TICK  = 2'd1,
		OP_FLUSH = 2'd2,
		OP_QUERY = 2'd3
	} op_t;

	typedef enum logic {
		KIND_PACKET = 1'b0,
		KIND_REPORT = 1'b1
	} kind_t;

endpackage

[design/overwriting_fifo_packetizer_top.sv]
// Byte ring buffer that overwrites its oldest byte and feeds fixed-size packets.
//
// Input channel (in_valid/in_stall) carries one command word: write a byte, packet
// tick, flush, or free-space query. Output channel (out_valid/out_stall) carries
// packet bytes (result_kind 0, last_byte marks the final byte) and space reports
// (result_kind 1).
// A write, flush, or tick that emits nothing completes in S_IDLE. A tick with the
// sink not ready also passes S_DROP to move the read pointer past the discarded
// bytes. A query is answered in the output register the cycle after acceptance.
// A packet tick streams PACKET_BYTES words, each byte through S_READ then S_LOAD:
// the ring RAM's registered read sits between address issue and output load.
// in_stall stays high until the last byte of the packet is in the output register.
// If the receiver stalls, the output register holds its word; the stream waits and
// a query is held off until the register frees. In S_IDLE others are still taken.
// Reset clears both pointers, the round counter and the output valid; the ring RAM
// is not cleared and needs no clearing pass.
module overwriting_fifo_packetizer_top #(
	parameter int BUFFER_BYTES      = ofp_pkg::BUFFER_BYTES_DEF,
	parameter int PACKET_BYTES      = ofp_pkg::PACKET_BYTES_DEF,
	parameter int PACKETS_PER_ROUND = ofp_pkg::PACKETS_PER_ROUND_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [ofp_pkg::OP_W-1:0]    operation,
	input  logic [ofp_pkg::BYTE_W-1:0]  data_byte,
	input  logic                        sink_ready,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        result_kind,
	output logic [ofp_pkg::BYTE_W-1:0]  out_byte,
	output logic                        last_byte,
	output logic [ofp_pkg::SPACE_W-1:0] free_space
);
	import ofp_pkg::*;

	localparam int AW  = $clog2(BUFFER_BYTES);
	localparam int AW1 = AW + 1;
	localparam int CW  = $clog2(PACKET_BYTES + 1);
	localparam int DW  = $clog2(PACKETS_PER_ROUND * PACKET_BYTES + 1);
	localparam int XW  = ((AW > DW) ? AW : DW) + 1;
	localparam logic [AW1-1:0] NB      = AW1'(BUFFER_BYTES);
	localparam logic [XW-1:0]  NB_X    = XW'(BUFFER_BYTES);
	localparam logic [CW-1:0]  LAST_CT = CW'(PACKET_BYTES - 1);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_READ = 4'b0010,
		S_LOAD = 4'b0100,
		S_DROP = 4'b1000
	} state_t;

	state_t               state_q;
	logic [AW-1:0]        rd_q, wr_q;
	logic [ROUND_W-1:0]   round_q;
	logic [CW-1:0]        cnt_q;
	logic [DW-1:0]        drop_n_q;
	logic                 out_valid_q;
	logic                 kind_q, last_q;
	logic [BYTE_W-1:0]    byte_q;
	logic [SPACE_W-1:0]   space_q;

	logic                 in_acc, out_free, empty;
	logic                 out_load;
	logic                 ram_we, ram_re;
	logic [BYTE_W-1:0]    ram_rdata;
	logic [AW-1:0]        rd_adv, wr_adv;
	logic [AW1-1:0]       occ, space;
	logic [XW-1:0]        drop_sum;

	function automatic logic [AW-1:0] adv(input logic [AW-1:0] idx);
		logic [AW1-1:0] nxt;
		nxt = AW1'(idx) + AW1'(1);
		return (nxt == NB) ? '0 : nxt[AW-1:0];
	endfunction

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE) ||
		((operation == OP_QUERY) && out_valid_q && out_stall);
	assign in_acc   = in_valid && !in_stall;
	assign empty    = (rd_q == wr_q);
	assign rd_adv   = adv(rd_q);
	assign wr_adv   = adv(wr_q);
	// a new word enters the output register
	assign out_load = (state_q == S_LOAD) || (in_acc && (operation == OP_QUERY));

	// occupancy and free space, both modulo the ring size
	assign occ   = (wr_q >= rd_q) ? (AW1'(wr_q) - AW1'(rd_q))
		: (AW1'(wr_q) + NB - AW1'(rd_q));
	assign space = (rd_q > wr_q) ? (AW1'(rd_q) - AW1'(wr_q))
		: (AW1'(rd_q) + NB - AW1'(wr_q));
	assign drop_sum = XW'(rd_q) + XW'(drop_n_q);

	assign ram_we = in_acc && (operation == OP_WRITE);
	assign ram_re = (state_q == S_READ);

	ofp_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (BUFFER_BYTES)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_q),
		.wdata (data_byte),
		.re    (ram_re),
		.raddr (rd_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rd_q        <= '0;
			wr_q        <= '0;
			round_q     <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						unique case (operation)
							OP_WRITE: begin
								// full ring: drop the oldest byte
								if (wr_adv == rd_q) begin
									rd_q <= rd_adv;
								end
								wr_q <= wr_adv;
							end
							OP_TICK: begin
								if (int'(round_q) >= PACKETS_PER_ROUND) begin
									round_q <= '0;
								end else if (!sink_ready) begin
									drop_n_q <= DW'((PACKETS_PER_ROUND - int'(round_q))
										* PACKET_BYTES);
									round_q  <= '0;
									state_q  <= S_DROP;
								end else begin
									round_q <= round_q + ROUND_W'(1);
									cnt_q   <= '0;
									state_q <= S_READ;
								end
							end
							OP_FLUSH: begin
								rd_q <= '0;
								wr_q <= '0;
							end
							OP_QUERY: begin
								kind_q      <= KIND_REPORT;
								byte_q      <= '0;
								last_q      <= 1'b1;
								space_q     <= SPACE_W'(space);
							end
							default: ;
						endcase
					end
				end
				S_READ: begin
					if (out_free) begin
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					// rd_q unchanged since the read was issued
					kind_q      <= KIND_PACKET;
					byte_q      <= empty ? '0 : ram_rdata;
					last_q      <= (cnt_q == LAST_CT);
					space_q     <= '0;
					if (!empty) begin
						rd_q <= rd_adv;
					end
					cnt_q   <= cnt_q + CW'(1);
					state_q <= (cnt_q == LAST_CT) ? S_IDLE : S_READ;
				end
				S_DROP: begin
					if (XW'(drop_n_q) >= XW'(occ)) begin
						rd_q <= wr_q;
					end else if (drop_sum >= NB_X) begin
						rd_q <= AW'(drop_sum - NB_X);
					end else begin
						rd_q <= AW'(drop_sum);
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign result_kind = kind_q;
	assign out_byte    = byte_q;
	assign last_byte   = last_q;
	assign free_space  = space_q;

endmodule

[design/ofp_ram.sv]
// Simple dual-port RAM, one write and one registered read port.
module ofp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[design/ofp_checker.sv]
// Port-level checker for the packetizer, bound to the top level.
`include "overwriting_fifo_packetizer_top_macros.svh"

module ofp_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic [ofp_pkg::OP_W-1:0]    operation,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic                        result_kind,
	input logic [ofp_pkg::BYTE_W-1:0]  out_byte,
	input logic                        last_byte,
	input logic [ofp_pkg::SPACE_W-1:0] free_space
);
	import ofp_pkg::*;

	// a report word is always a single, zero-byte, last word
	`OFP_ASSERT_NOW(a_report_shape, out_valid && (result_kind == KIND_REPORT), last_byte && (out_byte == '0) && (free_space != '0), "malformed space report")

	// mid-packet bytes mean the stream is running, so no command is taken
	`OFP_ASSERT_NOW(a_stream_blocks_input, out_valid && (result_kind == KIND_PACKET) && !last_byte, in_stall, "command taken during packet stream")

	// an accepted query shows its report in the next cycle
	`OFP_ASSERT_NEXT(a_query_report, in_valid && !in_stall && (operation == OP_QUERY), out_valid && (result_kind == KIND_REPORT), "query not answered")

	// a stalled output word holds
	`OFP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(last_byte) && $stable(result_kind), "stalled output changed")

endmodule

bind overwriting_fifo_packetizer_top ofp_checker u_ofp_checker (.*);
